FILE: src/rat_pkg.sv
// ---------------------------------------------------------------------------
// Rational arithmetic package
// Shared types, codes and field widths for the rational reduce unit.
// ---------------------------------------------------------------------------
package rat_pkg;

  // Default operand width.
  localparam int unsigned OperandWidth = 16;

  // Fixed widths of the result fields.
  localparam int unsigned ResNumW = 33;
  localparam int unsigned ResDenW = 31;
  localparam int unsigned WholeW  = 32;
  localparam int unsigned RemW    = 30;

  // Bit positions of the result fields in the output tdata.
  localparam int unsigned ResNumLsb = 0;
  localparam int unsigned ResDenLsb = ResNumLsb + ResNumW;
  localparam int unsigned NegLsb    = ResDenLsb + ResDenW;
  localparam int unsigned WholeLsb  = NegLsb + 1;
  localparam int unsigned RemLsb    = WholeLsb + WholeW;
  localparam int unsigned OutBits   = RemLsb + RemW;
  localparam int unsigned OutDataW  = ((OutBits + 7) / 8) * 8;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Which product the multiplier forms.
  typedef enum logic [1:0] {
    MUL_CROSS_A = 2'd0,
    MUL_CROSS_B = 2'd1,
    MUL_DEN     = 2'd2
  } mul_step_e;

  // Which division the shared divider runs.
  typedef enum logic [1:0] {
    DIV_NUM   = 2'd0,
    DIV_DEN   = 2'd1,
    DIV_MIXED = 2'd2
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      mul_en;
    mul_step_e mul_step;
    logic      comb;
    logic      gcd_init;
    logic      gcd_step;
    logic      g_cap;
    logic      div_start;
    div_sel_e  div_sel;
    logic      div_cap;
    logic      out_load;
  } rat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic mag_zero;
    logic gcd_done;
    logic div_done;
  } rat_sts_t;

endpackage

FILE: src/rat_div.sv
// ---------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient and remainder, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rat_div #(
  parameter int unsigned N = 33
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [N-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quo_o,
  output logic [N-1:0] rem_o
);

  localparam int unsigned CW = (N > 1) ? $clog2(N) : 1;

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [N:0]    rem_q, rem_d, shifted;
  logic [N-1:0]  quo_q, quo_d, dvs_q;
  logic          ge;

  // One shift and trial subtract per cycle.
  always_comb begin
    shifted = {rem_q[N-1:0], quo_q[N-1]};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? (shifted - {1'b0, dvs_q}) : shifted;
    quo_d   = {quo_q[N-2:0], ge};
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[N-1:0];

endmodule

FILE: src/rat_dp.sv
// ---------------------------------------------------------------------------
// Rational arithmetic datapath
// Cross products, sign handling, binary gcd, reducing divisions and result.
// ---------------------------------------------------------------------------
module rat_dp #(
  parameter int unsigned W = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [1:0]               op_i,
  input  logic signed [W-1:0]      a_num_i,
  input  logic signed [W-1:0]      a_den_i,
  input  logic signed [W-1:0]      b_num_i,
  input  logic signed [W-1:0]      b_den_i,
  input  rat_pkg::rat_cmd_t        cmd_i,
  output rat_pkg::rat_sts_t        sts_o,
  output logic signed [rat_pkg::ResNumW-1:0] res_num_o,
  output logic [rat_pkg::ResDenW-1:0]        res_den_o,
  output logic                     negative_o,
  output logic [rat_pkg::WholeW-1:0]         whole_part_o,
  output logic [rat_pkg::RemW-1:0]           remainder_part_o,
  output logic                     status_o
);
  import rat_pkg::*;

  localparam int unsigned PW = 2 * W;
  localparam int unsigned MW = 2 * W + 1;
  localparam int unsigned KW = $clog2(MW);

  // Operand registers.
  op_e                 op_q;
  logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic                zden_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      an_q   <= a_num_i;
      ad_q   <= a_den_i;
      bn_q   <= b_num_i;
      bd_q   <= b_den_i;
      zden_q <= (a_den_i == '0) || (b_den_i == '0);
    end
  end

  // One signed multiplier, operands chosen by step and operation.
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p0_q, p1_q, p2_q;

  always_comb begin
    case (cmd_i.mul_step)
      MUL_CROSS_A: begin
        mul_a = an_q;
        mul_b = (op_q == OP_MUL) ? bn_q : bd_q;
      end
      MUL_CROSS_B: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      MUL_DEN: begin
        mul_a = ad_q;
        mul_b = (op_q == OP_DIV) ? bn_q : bd_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
    endcase
    prod = PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_step)
        MUL_CROSS_A: p0_q <= prod;
        MUL_CROSS_B: p1_q <= prod;
        MUL_DEN:     p2_q <= prod;
        default:     p0_q <= prod;
      endcase
    end
  end

  // Combine products, then take magnitudes and the sign of the quotient.
  logic signed [MW-1:0] num_c, term_c, den_c;
  logic [MW-1:0]        mag_c, dmag_c;
  logic [MW-1:0]        mag_q, dmag_q;
  logic                 neg_q, den_zero_q, mag_zero_q;

  always_comb begin
    term_c = ((op_q == OP_ADD) || (op_q == OP_SUB)) ? MW'(p1_q) : '0;
    num_c  = (op_q == OP_SUB) ? (MW'(p0_q) - term_c) : (MW'(p0_q) + term_c);
    den_c  = MW'(p2_q);
    mag_c  = num_c[MW-1] ? MW'(-num_c) : MW'(num_c);
    dmag_c = den_c[MW-1] ? MW'(-den_c) : MW'(den_c);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.comb) begin
      mag_q      <= mag_c;
      dmag_q     <= dmag_c;
      neg_q      <= num_c[MW-1] ^ den_c[MW-1];
      den_zero_q <= (p2_q == '0);
      mag_zero_q <= (num_c == '0);
    end
  end

  // Binary gcd: shift out common and single factors of two, else subtract.
  logic [MW-1:0] u_q, v_q, g_q;
  logic [KW-1:0] k_q;
  logic          gcd_done;

  assign gcd_done = (u_q == '0) || (v_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      u_q <= mag_q;
      v_q <= dmag_q;
      k_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end
    if (cmd_i.g_cap) begin
      g_q <= MW'((u_q | v_q) << k_q);
    end
  end

  // Shared divider for both reductions and the mixed-number split.
  logic [MW-1:0] dvd, dvs, quo, rem;
  logic          div_done;
  logic [MW-1:0] q1_q, q2_q, whole_q, rem_q;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_NUM: begin
        dvd = mag_q;
        dvs = g_q;
      end
      DIV_DEN: begin
        dvd = dmag_q;
        dvs = g_q;
      end
      DIV_MIXED: begin
        dvd = q1_q;
        dvs = q2_q;
      end
      default: begin
        dvd = mag_q;
        dvs = g_q;
      end
    endcase
  end

  rat_div #(.N(MW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_cap) begin
      case (cmd_i.div_sel)
        DIV_NUM: q1_q <= quo;
        DIV_DEN: q2_q <= quo;
        DIV_MIXED: begin
          whole_q <= quo;
          rem_q   <= rem;
        end
        default: q1_q <= quo;
      endcase
    end
  end

  // Result register; error and zero results take fixed values.
  logic signed [MW:0] snum;
  logic               err;

  assign err  = zden_q | den_zero_q;
  assign snum = neg_q ? -$signed({1'b0, q1_q}) : $signed({1'b0, q1_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (err) begin
        res_num_o        <= '0;
        res_den_o        <= '0;
        negative_o       <= 1'b0;
        whole_part_o     <= '0;
        remainder_part_o <= '0;
        status_o         <= 1'b1;
      end else if (mag_zero_q) begin
        res_num_o        <= '0;
        res_den_o        <= ResDenW'(1);
        negative_o       <= 1'b0;
        whole_part_o     <= '0;
        remainder_part_o <= '0;
        status_o         <= 1'b0;
      end else begin
        res_num_o        <= ResNumW'(snum);
        res_den_o        <= ResDenW'(q2_q);
        negative_o       <= neg_q;
        whole_part_o     <= WholeW'(whole_q);
        remainder_part_o <= RemW'(rem_q);
        status_o         <= 1'b0;
      end
    end
  end

  assign sts_o.err      = err;
  assign sts_o.mag_zero = mag_zero_q;
  assign sts_o.gcd_done = gcd_done;
  assign sts_o.div_done = div_done;

endmodule

FILE: src/rat_ctrl.sv
// ---------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences the datapath through products, gcd and divisions per item.
// ---------------------------------------------------------------------------
module rat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              m_ready_i,
  output logic              m_valid_o,
  input  rat_pkg::rat_sts_t sts_i,
  output rat_pkg::rat_cmd_t cmd_o
);
  import rat_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_COMB, ST_SEL, ST_GCD,
    ST_DS1, ST_DW1, ST_DS2, ST_DW2, ST_DS3, ST_DW3, ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load = !out_valid_q || m_ready_i;

  // Commands and next state.
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL0;
        end
      end
      ST_MUL0: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MUL_CROSS_A;
        state_d        = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MUL_CROSS_B;
        state_d        = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MUL_DEN;
        state_d        = ST_COMB;
      end
      ST_COMB: begin
        cmd_o.comb = 1'b1;
        state_d    = ST_SEL;
      end
      ST_SEL: begin
        cmd_o.gcd_init = 1'b1;
        state_d = (sts_i.err || sts_i.mag_zero) ? ST_OUT : ST_GCD;
      end
      ST_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.g_cap = 1'b1;
          state_d     = ST_DS1;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DS1: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_NUM;
        state_d         = ST_DW1;
      end
      ST_DW1: begin
        cmd_o.div_sel = DIV_NUM;
        if (sts_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          state_d       = ST_DS2;
        end
      end
      ST_DS2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DEN;
        state_d         = ST_DW2;
      end
      ST_DW2: begin
        cmd_o.div_sel = DIV_DEN;
        if (sts_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          state_d       = ST_DS3;
        end
      end
      ST_DS3: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MIXED;
        state_d         = ST_DW3;
      end
      ST_DW3: begin
        cmd_o.div_sel = DIV_MIXED;
        if (sts_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          state_d       = ST_OUT;
        end
      end
      ST_OUT: begin
        if (can_load) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

endmodule

FILE: src/rational_arith_reduce_unit.sv
// Products, binary gcd steps and three bit-serial divisions lie between the accepting
// edge and m_axis_tvalid. One item is worked on at a time; a finished result waits in
// the output register while the next item is taken. Error and zero results skip the
// gcd and the divisions.
// Reset (rst_ni low) clears the controller and the output valid at once.
// ---------------------------------------------------------------------------
// Rational arithmetic reduce unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ---------------------------------------------------------------------------
module rational_arith_reduce_unit #(
  parameter int unsigned OPERAND_WIDTH = rat_pkg::OperandWidth,
  parameter int unsigned InDataW       = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // a_num, a_den, b_num, b_den from the lowest bit up
  input  logic [InDataW-1:0]           s_axis_tdata,
  // op
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // res_num, res_den, negative, whole_part, remainder_part from the lowest bit up
  output logic [rat_pkg::OutDataW-1:0] m_axis_tdata,
  // status
  output logic                         m_axis_tuser
);
  import rat_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;

  rat_cmd_t cmd;
  rat_sts_t sts;

  logic signed [ResNumW-1:0] res_num;
  logic [ResDenW-1:0]        res_den;
  logic                      negative;
  logic [WholeW-1:0]         whole_part;
  logic [RemW-1:0]           remainder_part;
  logic                      status;

  rat_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rat_dp #(.W(W)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (s_axis_tuser),
    .a_num_i          (s_axis_tdata[0*W +: W]),
    .a_den_i          (s_axis_tdata[1*W +: W]),
    .b_num_i          (s_axis_tdata[2*W +: W]),
    .b_den_i          (s_axis_tdata[3*W +: W]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .res_num_o        (res_num),
    .res_den_o        (res_den),
    .negative_o       (negative),
    .whole_part_o     (whole_part),
    .remainder_part_o (remainder_part),
    .status_o         (status)
  );

  // Pack the result fields.
  always_comb begin
    m_axis_tdata                       = '0;
    m_axis_tdata[ResNumLsb +: ResNumW] = res_num;
    m_axis_tdata[ResDenLsb +: ResDenW] = res_den;
    m_axis_tdata[NegLsb]               = negative;
    m_axis_tdata[WholeLsb +: WholeW]   = whole_part;
    m_axis_tdata[RemLsb +: RemW]       = remainder_part;
  end
  assign m_axis_tuser = status;

`ifndef SYNTHESIS
  // An error result carries all-zero fields.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result with nonzero fields");

  // A good result always has a nonzero denominator.
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[ResDenLsb +: ResDenW] != '0)
    else $error("zero denominator in good result");

  // After an item is taken, the unit is not ready in the next cycle.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");
`endif

endmodule

FILE: tb/sv/rational_arith_reduce_unit_test.sv
// ---------------------------------------------------------------------------
// Rational reduce unit testbench
// Drives fraction pairs with all four operations into the unit, predicts the
// reduced fraction and mixed-number split, and checks every returned item.
// ---------------------------------------------------------------------------
module rational_arith_reduce_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rat_pkg::*;

  localparam int unsigned W = OperandWidth;
  localparam int unsigned InW = ((4 * W + 7) / 8) * 8;
  localparam int NumRandom = 1330;

  // One expected result item, laid out as {tdata fields from the top down, tuser}.
  typedef struct packed {
    logic [RemW-1:0]    rem;
    logic [WholeW-1:0]  whole;
    logic               neg;
    logic [ResDenW-1:0] den;
    logic [ResNumW-1:0] num;
    logic               err;
  } frac_res_t;

  // Predicts results of accepted fractions and checks returned items.
  class frac_scoreboard;
    frac_res_t pending[$];
    int mismatches;

    function longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return (a == 0) ? 1 : a;
    endfunction

    function void note_fraction(op_e op, logic signed [W-1:0] an, logic signed [W-1:0] ad,
                                logic signed [W-1:0] bn, logic signed [W-1:0] bd);
      frac_res_t r;
      longint num, den;
      longint unsigned mag, dmag, g;
      r = '0;
      if (ad == 0 || bd == 0) begin
        r.err = 1'b1;
        pending.push_back(r);
        return;
      end
      den = longint'(ad) * longint'(bd);
      case (op)
        OP_ADD: num = longint'(an) * bd + longint'(bn) * ad;
        OP_SUB: num = longint'(an) * bd - longint'(bn) * ad;
        OP_MUL: num = longint'(an) * bn;
        default: begin
          num = longint'(an) * bd;
          den = longint'(ad) * bn;
        end
      endcase
      if (den == 0) begin
        r.err = 1'b1;
      end else begin
        if (den < 0) begin
          num = -num;
          den = -den;
        end
        if (num == 0) begin
          r.den = ResDenW'(1);
        end else begin
          r.neg = num < 0;
          mag = r.neg ? -num : num;
          dmag = den;
          g = euclid_gcd(mag, dmag);
          mag = mag / g;
          dmag = dmag / g;
          r.num = ResNumW'(r.neg ? -mag : mag);
          r.den = ResDenW'(dmag);
          r.whole = WholeW'(mag / dmag);
          r.rem = RemW'(mag % dmag);
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(frac_res_t got);
      frac_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp num %0h den %0h neg %0b whole %0h rem %0h err %0b",
                    " / got num %0h den %0h neg %0b whole %0h rem %0h err %0b"},
                   exp_r.num, exp_r.den, exp_r.neg, exp_r.whole, exp_r.rem, exp_r.err,
                   got.num, got.den, got.neg, got.whole, got.rem, got.err);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  frac_scoreboard sb = new();
  bit hold_sink = 1'b0;
  bit sending_done = 1'b0;

  always #2 clk_i = ~clk_i;

  rational_arith_reduce_unit dut (.*);

  // Sends one fraction pair and waits until it is accepted.
  task automatic send_fraction(op_e op, int an, int ad, int bn, int bd, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= InW'({W'(bd), W'(bn), W'(ad), W'(an)});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_fraction(op, W'(an), W'(ad), W'(bn), W'(bd));
  endtask

  // Random operand with a bias toward small magnitudes and extremes.
  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(W-1){1'b0}}};
      1: return {1'b0, {(W-1){1'b1}}};
      2, 3: return W'($signed($urandom_range(0, 14)) - 7);
      4, 5: return W'($urandom_range(0, 255));
      default: return W'($urandom);
    endcase
  endfunction

  // Stimulus.
  initial begin
    logic [W-1:0] mx, mn;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int o = 0; o < 4; o++) begin
      send_fraction(op_e'(o), 1, 2, 1, 3, 1'b0);
      send_fraction(op_e'(o), mx, mn, mn, mx, 1'b0);
      send_fraction(op_e'(o), mn, 1, mn, mn, 1'b0);
      send_fraction(op_e'(o), 3, -4, -5, 6, 1'b0);
    end
    send_fraction(OP_ADD, 5, 0, 1, 2, 1'b0);
    send_fraction(OP_MUL, 1, 2, 5, 0, 1'b0);
    send_fraction(OP_DIV, 1, 2, 0, 7, 1'b0);
    send_fraction(OP_SUB, 2, 4, 1, 2, 1'b0);
    send_fraction(OP_MUL, 0, 9, 3, 5, 1'b0);
    send_fraction(OP_DIV, mn, 1, 1, mx, 1'b0);
    send_fraction(OP_ADD, '1, '1, '1, '1, 1'b0);
    // Pause until every result has come back.
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 300) hold_sink = 1'b1;
      send_fraction(op_e'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                    pick_operand(), pick_operand(), 1'b1);
      if (i == 700) begin
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result side with random stalls and one long hold-off.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    forever begin
      if (hold_sink && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (1500) @(posedge clk_i);
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_result({m_axis_tdata[OutBits-1:0], m_axis_tuser});
    end
  end

  // End of run.
  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #10000000;
    $display("tb: failure");
    $finish;
  end
endmodule
